/* hw/rtl/vfpl_pkg.sv */
// Types, constants, format table and microcode for the frame plane layout unit.
`default_nettype none
package vfpl_pkg;

    localparam int MAX_PLANES   = 4;
    localparam int DIM_BITS_DEF = 16;

    localparam int FMT_W    = 4;
    localparam int DIM_W    = 16;
    localparam int PIDX_W   = 2;
    localparam int ROWS_W   = 18;
    localparam int STRIDE_W = 19;
    localparam int SIZE_W   = 35;
    localparam int ALIGN_W  = 4;
    localparam int PAD_W    = 8;
    localparam int CIDX_W   = 1;
    localparam int CDATA_W  = 8;
    localparam int BPE_W    = 3;
    localparam int NPL_W    = 3;
    localparam int STEP_W   = 4;

    localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 4'd8;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;
    localparam logic [PAD_W-1:0]   PAD_RESET   = 8'd16;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ALIGN = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_PAD   = 1'b1;

    typedef enum logic [FMT_W-1:0] {
        FMT_I420  = 4'd0,
        FMT_YV12  = 4'd1,
        FMT_YV16  = 4'd2,
        FMT_YV12A = 4'd3,
        FMT_YV24  = 4'd4,
        FMT_NV12  = 4'd5,
        FMT_NV21  = 4'd6,
        FMT_UYVY  = 4'd7,
        FMT_YUY2  = 4'd8,
        FMT_ARGB  = 4'd9,
        FMT_XRGB  = 4'd10,
        FMT_RGB24 = 4'd11,
        FMT_RGB32 = 4'd12,
        FMT_MJPEG = 4'd13,
        FMT_MT21  = 4'd14
    } t_format;

    // per-plane fields indexed by plane number; subsampling kept as log2 (0 or 1)
    typedef struct packed {
        logic                             valid;
        logic [NPL_W-1:0]                 planes;
        logic [MAX_PLANES-1:0][BPE_W-1:0] bpe;
        logic [MAX_PLANES-1:0]            sw_log;
        logic [MAX_PLANES-1:0]            sh_log;
        logic                             max_w_log;
        logic                             max_h_log;
    } t_fmt;

    function automatic t_fmt fmt_lookup(input logic [FMT_W-1:0] code);
        t_fmt f;
        f = '0;
        f.valid = 1'b1;
        unique case (code)
            FMT_I420, FMT_YV12: begin
                f.planes = 3'd3; f.bpe = {3'd0, 3'd1, 3'd1, 3'd1};
                f.sw_log = 4'b0110; f.sh_log = 4'b0110;
                f.max_w_log = 1'b1; f.max_h_log = 1'b1;
            end
            FMT_YV16: begin
                f.planes = 3'd3; f.bpe = {3'd0, 3'd1, 3'd1, 3'd1};
                f.sw_log = 4'b0110; f.sh_log = 4'b0000;
                f.max_w_log = 1'b1; f.max_h_log = 1'b0;
            end
            FMT_YV12A: begin
                f.planes = 3'd4; f.bpe = {3'd1, 3'd1, 3'd1, 3'd1};
                f.sw_log = 4'b0110; f.sh_log = 4'b0110;
                f.max_w_log = 1'b1; f.max_h_log = 1'b1;
            end
            FMT_YV24: begin
                f.planes = 3'd3; f.bpe = {3'd0, 3'd1, 3'd1, 3'd1};
            end
            FMT_NV12, FMT_NV21, FMT_MT21: begin
                f.planes = 3'd2; f.bpe = {3'd0, 3'd0, 3'd2, 3'd1};
                f.sw_log = 4'b0010; f.sh_log = 4'b0010;
                f.max_w_log = 1'b1; f.max_h_log = 1'b1;
            end
            FMT_UYVY, FMT_YUY2: begin
                f.planes = 3'd1; f.bpe = {3'd0, 3'd0, 3'd0, 3'd2};
            end
            FMT_ARGB, FMT_XRGB, FMT_RGB32: begin
                f.planes = 3'd1; f.bpe = {3'd0, 3'd0, 3'd0, 3'd4};
            end
            FMT_RGB24: begin
                f.planes = 3'd1; f.bpe = {3'd0, 3'd0, 3'd0, 3'd3};
            end
            FMT_MJPEG: begin
                f.planes = 3'd1;
            end
            default: begin
                f.valid = 1'b0;
            end
        endcase
        return f;
    endfunction

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_GEOM,
        OP_MUL,
        OP_ACC,
        OP_EMIT,
        OP_FINAL,
        OP_EMIT_LAST
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_BAD,
        C_LASTP
    } t_cond;

    typedef struct packed {
        t_op               op;
        logic              wait_in;
        logic              wait_out;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // program addresses
    localparam logic [STEP_W-1:0] S_LOAD   = 4'd0;
    localparam logic [STEP_W-1:0] S_CHECK  = 4'd1;
    localparam logic [STEP_W-1:0] S_GEOM   = 4'd2;
    localparam logic [STEP_W-1:0] S_MUL    = 4'd3;
    localparam logic [STEP_W-1:0] S_ACC    = 4'd4;
    localparam logic [STEP_W-1:0] S_EMIT   = 4'd5;
    localparam logic [STEP_W-1:0] S_FINAL  = 4'd6;
    localparam logic [STEP_W-1:0] S_BADSET = 4'd7;
    localparam logic [STEP_W-1:0] S_LAST   = 4'd8;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS, target: S_LOAD};
        unique case (step)
            S_LOAD:   begin w.op = OP_LOAD; w.wait_in = 1'b1; w.cond = C_NEXT; end
            S_CHECK:  begin w.cond = C_BAD; w.target = S_BADSET; end
            S_GEOM:   begin w.op = OP_GEOM; w.cond = C_NEXT; end
            S_MUL:    begin w.op = OP_MUL; w.cond = C_NEXT; end
            S_ACC:    begin w.op = OP_ACC; w.cond = C_LASTP; w.target = S_FINAL; end
            S_EMIT:   begin w.op = OP_EMIT; w.wait_out = 1'b1; w.target = S_GEOM; end
            S_FINAL:  begin w.op = OP_FINAL; w.target = S_LAST; end
            S_BADSET: begin w.op = OP_NOP; w.cond = C_NEXT; end
            S_LAST:   begin w.op = OP_EMIT_LAST; w.wait_out = 1'b1; w.target = S_LOAD; end
            default:  begin w.target = S_LOAD; end
        endcase
        return w;
    endfunction

    typedef struct packed {
        t_op  op;
        logic go;
    } t_ctrl;

    typedef struct packed {
        logic bad;
        logic last_plane;
    } t_stat;

    typedef struct packed {
        logic [PIDX_W-1:0]   plane_index;
        logic [ROWS_W-1:0]   plane_rows;
        logic [STRIDE_W-1:0] line_stride;
        logic [SIZE_W-1:0]   plane_offset;
        logic [SIZE_W-1:0]   total_size;
        logic                last;
        logic                bad_format;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/vfpl_if.sv */
// Channel interfaces: request, result and configuration write.
`default_nettype none
interface vfpl_in_if;
    import vfpl_pkg::*;
    logic               valid;
    logic               ready;
    logic [FMT_W-1:0]   format_code;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    modport source (output valid, format_code, frame_width, frame_height, input ready);
    modport sink   (input valid, format_code, frame_width, frame_height, output ready);
endinterface

interface vfpl_out_if;
    import vfpl_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIDX_W-1:0]   plane_index;
    logic [ROWS_W-1:0]   plane_rows;
    logic [STRIDE_W-1:0] line_stride;
    logic [SIZE_W-1:0]   plane_offset;
    logic [SIZE_W-1:0]   total_size;
    logic                last;
    logic                bad_format;
    modport source (output valid, plane_index, plane_rows, line_stride, plane_offset,
                    total_size, last, bad_format, input ready);
    modport sink   (input valid, plane_index, plane_rows, line_stride, plane_offset,
                    total_size, last, bad_format, output ready);
endinterface

interface vfpl_cfg_if;
    import vfpl_pkg::*;
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  reg_index;
    logic [CDATA_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

/* hw/rtl/video_frame_plane_layout_unit.sv */
// Top level of the frame plane layout unit: config registers, result register, wiring.
//
//  channel | dir | port  | transaction carries
//  --------+-----+-------+---------------------------------------------------
//  request | in  | i_in  | format_code, frame_width, frame_height
//  result  | out | o_out | plane_index, plane_rows, line_stride, plane_offset,
//          |     |       | total_size, last, bad_format
//  config  | in  | i_cfg | reg_index (0 align_log2, 1 pad_bytes), wdata
//
// The microcode loop walks the planes of a request one after another with one
//   shared multiplier; an unknown format skips the loop and yields a single result.
// A new request is taken once the sequencer is back at its load step; a finished
//   result may still wait in the output register then.
// Reset (synchronous, active low) clears the step counter, the output valid and
//   the config registers (align_log2 = 4, pad_bytes = 16).
// Back-pressure on o_out holds the sequencer at its emit or last-result step; nothing is lost.
// Config writes are always accepted and must only happen while the unit is idle.
`default_nettype none
module video_frame_plane_layout_unit #(
    parameter int DIM_BITS = vfpl_pkg::DIM_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vfpl_in_if.sink    i_in,
    vfpl_out_if.source o_out,
    vfpl_cfg_if.sink   i_cfg
);
    import vfpl_pkg::*;

    logic [ALIGN_W-1:0] r_align_log2;
    logic [PAD_W-1:0]   r_pad_bytes;
    logic               r_out_valid;
    t_result            r_out;

    t_ctrl   ctrl;
    t_stat   stat;
    t_result result;
    logic    out_free;
    logic    out_load;

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ctrl.go && (ctrl.op == OP_EMIT || ctrl.op == OP_EMIT_LAST);

    vfpl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (i_in.ready)
    );

    vfpl_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_ctrl         (ctrl),
        .i_format_code  (i_in.format_code),
        .i_frame_width  (i_in.frame_width),
        .i_frame_height (i_in.frame_height),
        .i_align_log2   (r_align_log2),
        .i_pad_bytes    (r_pad_bytes),
        .o_stat         (stat),
        .o_result       (result)
    );

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_log2 <= ALIGN_RESET;
            r_pad_bytes  <= PAD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_ALIGN: r_align_log2 <= i_cfg.wdata[ALIGN_W-1:0];
                CFG_PAD:   r_pad_bytes  <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.plane_index  = r_out.plane_index;
    assign o_out.plane_rows   = r_out.plane_rows;
    assign o_out.line_stride  = r_out.line_stride;
    assign o_out.plane_offset = r_out.plane_offset;
    assign o_out.total_size   = r_out.total_size;
    assign o_out.last         = r_out.last;
    assign o_out.bad_format   = r_out.bad_format;

endmodule
`default_nettype wire

/* hw/rtl/vfpl_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module vfpl_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_free,
    input  wire vfpl_pkg::t_stat i_stat,
    output vfpl_pkg::t_ctrl      o_ctrl,
    output logic                 o_in_ready
);
    import vfpl_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              stall;
    logic              take;

    always_comb begin
        uw    = ucode(r_step);
        stall = (uw.wait_in && !i_in_valid) || (uw.wait_out && !i_out_free);
        unique case (uw.cond)
            C_NEXT:   take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_BAD:    take = i_stat.bad;
            C_LASTP:  take = i_stat.last_plane;
            default:  take = 1'b0;
        endcase
        if (stall) begin
            n_step = r_step;
        end else if (take) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
        o_ctrl.op  = uw.op;
        o_ctrl.go  = !stall;
        o_in_ready = uw.wait_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/vfpl_dp.sv */
// Layout datapath: size alignment, rows/stride per plane, shared multiplier, accumulator.
`default_nettype none
module vfpl_dp #(
    parameter int DIM_BITS = vfpl_pkg::DIM_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire vfpl_pkg::t_ctrl               i_ctrl,
    input  wire logic [vfpl_pkg::FMT_W-1:0]    i_format_code,
    input  wire logic [vfpl_pkg::DIM_W-1:0]    i_frame_width,
    input  wire logic [vfpl_pkg::DIM_W-1:0]    i_frame_height,
    input  wire logic [vfpl_pkg::ALIGN_W-1:0]  i_align_log2,
    input  wire logic [vfpl_pkg::PAD_W-1:0]    i_pad_bytes,
    output vfpl_pkg::t_stat                    o_stat,
    output vfpl_pkg::t_result                  o_result
);
    import vfpl_pkg::*;

    localparam int DW     = DIM_BITS + 1;
    localparam int PROD_W = ROWS_W + STRIDE_W;

    logic [FMT_W-1:0]    r_code;
    logic [DW-1:0]       r_w;
    logic [DW-1:0]       r_h;
    logic [PIDX_W-1:0]   r_plane;
    logic [ROWS_W-1:0]   r_rows;
    logic [STRIDE_W-1:0] r_stride;
    logic [STRIDE_W-1:0] r_stride1;
    logic [SIZE_W-1:0]   r_prod;
    logic [SIZE_W-1:0]   r_offset;
    logic [SIZE_W-1:0]   r_size;

    t_fmt                fmt;
    t_fmt                fmt_in;
    logic [ALIGN_W-1:0]  sh;
    logic [9:0]          row_mask;
    logic [8:0]          col_mask;
    logic [DW-1:0]       w_ext;
    logic [DW-1:0]       h_ext;
    logic [DW-1:0]       n_w;
    logic [DW-1:0]       n_h;
    logic [DW-1:0]       hs;
    logic [DW-1:0]       cols;
    logic [ROWS_W-1:0]   n_rows;
    logic [STRIDE_W-1:0] row_bytes;
    logic [STRIDE_W-1:0] n_stride;
    logic [PROD_W-1:0]   prod;

    always_comb begin
        fmt    = fmt_lookup(r_code);
        fmt_in = fmt_lookup(i_format_code);
        sh     = (i_align_log2 > ALIGN_MAX) ? ALIGN_MAX : i_align_log2;
        // masks for 2*A and A
        row_mask = (10'd2 << sh) - 10'd1;
        col_mask = 9'((10'd1 << sh) - 10'd1);

        // round the coded size up to the largest subsampling (1 or 2)
        w_ext = DW'(i_frame_width[DIM_BITS-1:0]);
        h_ext = DW'(i_frame_height[DIM_BITS-1:0]);
        n_w   = (w_ext + DW'(fmt_in.max_w_log)) & ~DW'(fmt_in.max_w_log);
        n_h   = (h_ext + DW'(fmt_in.max_h_log)) & ~DW'(fmt_in.max_h_log);

        hs        = r_h >> fmt.sh_log[r_plane];
        cols      = r_w >> fmt.sw_log[r_plane];
        n_rows    = (ROWS_W'(hs) + ROWS_W'(row_mask)) & ~ROWS_W'(row_mask);
        row_bytes = STRIDE_W'(cols) * STRIDE_W'(fmt.bpe[r_plane]);
        n_stride  = (row_bytes + STRIDE_W'(col_mask)) & ~STRIDE_W'(col_mask);

        prod = PROD_W'(r_rows) * PROD_W'(r_stride);

        o_stat.bad        = !fmt.valid;
        o_stat.last_plane = (NPL_W'(r_plane) == (fmt.planes - NPL_W'(1)));

        o_result.plane_index  = r_plane;
        o_result.plane_rows   = r_rows;
        o_result.line_stride  = r_stride;
        o_result.plane_offset = r_offset;
        o_result.total_size   = r_size;
        o_result.last         = (i_ctrl.op == OP_EMIT_LAST);
        o_result.bad_format   = !fmt.valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.go) begin
            unique case (i_ctrl.op)
                OP_LOAD: begin
                    r_code    <= i_format_code;
                    r_w       <= n_w;
                    r_h       <= n_h;
                    r_plane   <= '0;
                    r_size    <= '0;
                    r_stride1 <= '0;
                    // cleared here so an unknown format reports zeros
                    r_rows    <= '0;
                    r_stride  <= '0;
                    r_offset  <= '0;
                end
                OP_GEOM: begin
                    r_rows   <= n_rows;
                    r_stride <= n_stride;
                end
                OP_MUL: begin
                    r_prod <= prod[SIZE_W-1:0];
                end
                OP_ACC: begin
                    r_offset <= r_size;
                    r_size   <= r_size + r_prod;
                    if (r_plane == PIDX_W'(1)) begin
                        r_stride1 <= r_stride;
                    end
                end
                OP_EMIT: begin
                    r_plane <= r_plane + PIDX_W'(1);
                end
                OP_FINAL: begin
                    // extra line of plane 1 (zero for one-plane formats) and padding
                    r_size <= r_size + SIZE_W'(r_stride1) + SIZE_W'(i_pad_bytes);
                end
                OP_NOP, OP_EMIT_LAST: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/vfpl_checker.sv */
// Port-level checks for the frame plane layout unit, bound to the top level.
`default_nettype none
module vfpl_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [vfpl_pkg::PIDX_W-1:0]   i_plane_index,
    input wire logic [vfpl_pkg::ROWS_W-1:0]   i_plane_rows,
    input wire logic [vfpl_pkg::STRIDE_W-1:0] i_line_stride,
    input wire logic [vfpl_pkg::SIZE_W-1:0]   i_plane_offset,
    input wire logic [vfpl_pkg::SIZE_W-1:0]   i_total_size,
    input wire logic                          i_last,
    input wire logic                          i_bad_format
);
    // busy after taking a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in progress");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_format |-> i_last)
        else $error("unknown format result not marked last");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_format |-> i_plane_rows == '0 && i_line_stride == '0
            && i_plane_offset == '0 && i_total_size == '0 && i_plane_index == '0)
        else $error("unknown format result carries non-zero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_plane_index, i_plane_rows, i_line_stride, i_plane_offset,
                        i_total_size, i_last, i_bad_format}))
        else $error("stalled result changed or dropped");

endmodule

bind video_frame_plane_layout_unit vfpl_checker u_vfpl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_plane_index  (o_out.plane_index),
    .i_plane_rows   (o_out.plane_rows),
    .i_line_stride  (o_out.line_stride),
    .i_plane_offset (o_out.plane_offset),
    .i_total_size   (o_out.total_size),
    .i_last         (o_out.last),
    .i_bad_format   (o_out.bad_format)
);
`default_nettype wire
